// File: hdl/pbs_pkg.sv
`default_nettype none

package pbs_pkg;

    // Fixed geometry of the fields and of the access window.
    localparam int BYTE_BITS       = 8;
    localparam int WORD_BITS       = 32;
    localparam int OFFSET_W        = 16;
    localparam int LEN_W           = 6;
    localparam int VALUE_W         = 32;
    localparam int BOUND_W         = 33;
    localparam int CMD_W           = 2;
    localparam int KIDX_W          = 3;
    // A field of up to 32 bits that starts anywhere in a byte touches at most five bytes.
    localparam int WIN_BITS        = 40;
    // Byte part of a bit offset.
    localparam int BYTE_OFF_W      = OFFSET_W - 3;
    localparam int STORE_BYTES_DEF = 1024;
    // Scale of the reciprocal used to reduce byte addresses modulo the store size.
    localparam int RECIP_SHIFT     = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ_U = 2'd0,
        CMD_READ_S = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_UNUSED = 2'd3
    } pbs_cmd_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_XFER,
        ST_DRAIN,
        ST_EXTRACT,
        ST_CLAMP_LO,
        ST_CLAMP_HI,
        ST_DONE
    } pbs_state_t;

    typedef struct packed {
        logic load;
        logic base_en;
        logic issue;
        logic ext_en;
        logic clo_en;
        logic chi_en;
        logic out_load;
    } pbs_ctrl_t;

    typedef struct packed {
        logic is_read;
        logic is_write;
        logic last_byte;
        logic no_bytes;
    } pbs_status_t;

endpackage

`default_nettype wire

// File: hdl/pbs_ctrl.sv
`default_nettype none

module pbs_ctrl
    import pbs_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  wire         out_ready,
    input  pbs_status_t status,
    output pbs_ctrl_t   cmd
);

    pbs_state_t state_reg;
    pbs_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                cmd.base_en = 1'b1;
                if ((!status.is_read && !status.is_write) || status.no_bytes)
                begin
                    state_next = status.is_read ? ST_EXTRACT : ST_DONE;
                end
                else
                begin
                    state_next = ST_XFER;
                end
            end
            ST_XFER:
            begin
                cmd.issue = 1'b1;
                if (status.last_byte)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = status.is_read ? ST_EXTRACT : ST_DONE;
            end
            ST_EXTRACT:
            begin
                cmd.ext_en = 1'b1;
                state_next = ST_CLAMP_LO;
            end
            ST_CLAMP_LO:
            begin
                cmd.clo_en = 1'b1;
                state_next = ST_CLAMP_HI;
            end
            ST_CLAMP_HI:
            begin
                cmd.chi_en = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // A finished result never replaces one that has not been transferred.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before transfer");

    // Field extraction only runs for read commands.
    a_extract_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ext_en |-> status.is_read)
        else $error("extraction started for a non-read command");

endmodule

`default_nettype wire

// File: hdl/pbs_datapath.sv
`default_nettype none

module pbs_datapath
    import pbs_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  pbs_ctrl_t                  cmd,
    output pbs_status_t                status,
    input  wire         [CMD_W-1:0]    command,
    input  wire         [OFFSET_W-1:0] bit_offset,
    input  wire         [LEN_W-1:0]    field_length,
    input  wire         [VALUE_W-1:0]  write_value,
    input  wire  signed [BOUND_W-1:0]  lower_bound,
    input  wire  signed [BOUND_W-1:0]  upper_bound,
    input  wire         [LEN_W-1:0]    type_bits,
    output logic signed [BOUND_W-1:0]  read_value,
    output logic                       length_error
);

    localparam int ADDR_W   = $clog2(STORE_BYTES);
    localparam int RECIP_W  = RECIP_SHIFT - 2;
    localparam int PROD_W   = BYTE_OFF_W + RECIP_W;
    localparam int Q_W      = PROD_W - RECIP_SHIFT;
    localparam int R_W      = BYTE_OFF_W + 1;
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((2 ** RECIP_SHIFT) / STORE_BYTES);
    localparam logic [R_W-1:0]     N_R      = R_W'(STORE_BYTES);
    localparam logic [ADDR_W-1:0]  LAST_ADR = ADDR_W'(STORE_BYTES - 1);

    logic [BYTE_BITS-1:0]         store_reg [STORE_BYTES];
    logic [BYTE_BITS-1:0]         rdata_reg;

    pbs_cmd_code_t                cmd_reg;
    logic [2:0]                   bo_reg;
    logic [LEN_W-1:0]             len_reg;
    logic [KIDX_W-1:0]            nb_reg;
    logic                         err_reg;
    logic signed [BOUND_W-1:0]    lo_reg;
    logic signed [BOUND_W-1:0]    hi_reg;
    logic [WIN_BITS-1:0]          wdat_reg;
    logic [WIN_BITS-1:0]          wmask_reg;
    logic [BYTE_OFF_W-1:0]        x_reg;
    logic [Q_W-1:0]               q_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic [ADDR_W-1:0]            addr_next;
    logic [KIDX_W-1:0]            k_reg;
    logic [WIN_BITS-1:0]          acc_reg;
    logic signed [BOUND_W-1:0]    val_reg;
    logic signed [BOUND_W-1:0]    val_next;
    logic                         pend_reg;
    logic [ADDR_W-1:0]            pend_addr_reg;
    logic [KIDX_W-1:0]            pend_k_reg;
    logic signed [BOUND_W-1:0]    read_value_reg;
    logic                         length_error_reg;

    // Input side decode.
    logic [LEN_W-1:0]             len_clip;
    logic [LEN_W-1:0]             span;
    logic                         in_signed;
    logic [VALUE_W-1:0]           lv_w;
    logic [VALUE_W-1:0]           lmask_w;
    logic [PROD_W-1:0]            recip_prod;

    // Address reduction.
    logic [R_W-1:0]               qn;
    logic [R_W-1:0]               rem;
    logic [ADDR_W-1:0]            base_addr;

    // Byte merge and extraction.
    logic [5:0]                   pend_pos;
    logic [BYTE_BITS-1:0]         merged;
    logic [WIN_BITS-1:0]          win_sh;
    logic [VALUE_W-1:0]           lv_r;
    logic signed [BOUND_W-1:0]    u_val;
    logic signed [BOUND_W-1:0]    s_val;
    logic                         is_read;
    logic                         is_write;

    always_comb
    begin
        len_clip   = (field_length > LEN_W'(WORD_BITS)) ? LEN_W'(WORD_BITS) : field_length;
        span       = LEN_W'({3'b000, bit_offset[2:0]}) + len_clip + LEN_W'(BYTE_BITS - 1);
        in_signed  = (command == CMD_READ_S);
        lv_w       = write_value << (LEN_W'(WORD_BITS) - len_clip);
        lmask_w    = ~({VALUE_W{1'b1}} >> len_clip);
        recip_prod = PROD_W'(bit_offset[OFFSET_W-1:3]) * PROD_W'(RECIP);
    end

    always_comb
    begin
        qn        = R_W'(q_reg * N_R);
        rem       = {1'b0, x_reg} - qn;
        base_addr = (rem >= N_R) ? ADDR_W'(rem - N_R) : ADDR_W'(rem);
        addr_next = (addr_reg == LAST_ADR) ? '0 : addr_reg + 1'b1;
    end

    assign is_read  = (cmd_reg == CMD_READ_U) || (cmd_reg == CMD_READ_S);
    assign is_write = (cmd_reg == CMD_WRITE);

    always_comb
    begin
        pend_pos = 6'(WIN_BITS - 1 - BYTE_BITS * int'(pend_k_reg));
        merged   = (rdata_reg & ~wmask_reg[pend_pos -: BYTE_BITS])
                 | (wdat_reg[pend_pos -: BYTE_BITS] & wmask_reg[pend_pos -: BYTE_BITS]);
    end

    // The field sits at the top of the shifted window; shifting down keeps its length.
    always_comb
    begin
        win_sh = acc_reg << bo_reg;
        lv_r   = win_sh[WIN_BITS-1 -: VALUE_W];
        u_val  = $signed({1'b0, lv_r} >> (LEN_W'(WORD_BITS) - len_reg));
        s_val  = $signed({lv_r, 1'b0}) >>> (LEN_W'(WORD_BITS + 1) - len_reg);
    end

    always_comb
    begin
        val_next = val_reg;
        if (cmd.ext_en)
        begin
            val_next = (cmd_reg == CMD_READ_S) ? s_val : u_val;
        end
        else if (cmd.clo_en)
        begin
            if (val_reg < lo_reg)
            begin
                val_next = lo_reg;
            end
        end
        else if (cmd.chi_en)
        begin
            if (val_reg > hi_reg)
            begin
                val_next = hi_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rdata_reg <= store_reg[addr_reg];
        end
        if (pend_reg && is_write)
        begin
            store_reg[pend_addr_reg] <= merged;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= pbs_cmd_code_t'(command);
            bo_reg    <= bit_offset[2:0];
            len_reg   <= len_clip;
            // A zero-length field touches no byte at all.
            nb_reg    <= (len_clip == '0) ? '0 : span[LEN_W-1:3];
            err_reg   <= (field_length > type_bits);
            lo_reg    <= {in_signed & lower_bound[VALUE_W-1], lower_bound[VALUE_W-1:0]};
            hi_reg    <= {in_signed & upper_bound[VALUE_W-1], upper_bound[VALUE_W-1:0]};
            wdat_reg  <= {lv_w, 8'h00} >> bit_offset[2:0];
            wmask_reg <= {lmask_w, 8'h00} >> bit_offset[2:0];
            x_reg     <= bit_offset[OFFSET_W-1:3];
            q_reg     <= recip_prod[PROD_W-1:RECIP_SHIFT];
            acc_reg   <= '0;
        end
        else if (pend_reg && is_read)
        begin
            acc_reg[pend_pos -: BYTE_BITS] <= rdata_reg;
        end

        if (cmd.base_en)
        begin
            addr_reg <= base_addr;
            k_reg    <= '0;
        end
        else if (cmd.issue)
        begin
            addr_reg <= addr_next;
            k_reg    <= k_reg + 1'b1;
        end

        if (cmd.issue)
        begin
            pend_addr_reg <= addr_reg;
            pend_k_reg    <= k_reg;
        end

        val_reg <= val_next;

        if (cmd.out_load)
        begin
            read_value_reg   <= is_read ? val_reg : '0;
            length_error_reg <= is_read & err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.issue;
        end
    end

    assign status.is_read   = is_read;
    assign status.is_write  = is_write;
    assign status.last_byte = (KIDX_W'(k_reg + 1'b1) == nb_reg);
    assign status.no_bytes  = (nb_reg == '0);

    assign read_value   = read_value_reg;
    assign length_error = length_error_reg;

    // A pending byte always belongs to the read issued in the previous cycle.
    a_pend_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(cmd.issue))
        else $error("pending byte without a preceding read");

    // The reduced start address always lies inside the store.
    a_base_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.base_en |=> (int'(addr_reg) < STORE_BYTES))
        else $error("start address outside the store");

    // No byte beyond the span of the field is ever accessed.
    a_issue_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (k_reg < nb_reg))
        else $error("byte access beyond the field span");

endmodule

`default_nettype wire

// File: hdl/packed_bitfield_store.sv
`default_nettype none

// Byte-wide store of STORE_BYTES bytes holding bit fields packed MSB first,
// addressed by a global bit offset (bit 0 is the MSB of byte 0); byte addresses
// wrap at the end of the store. Each input transfer carries one command: an
// unsigned read, a signed read (sign-extended) or a write, and every command
// yields exactly one output transfer. Reads clamp the field against
// lower_bound first and upper_bound second, so the upper bound wins when the
// two cross, and flag length_error when field_length exceeds type_bits (the
// read still completes). Writes return zero. Items are handled one at a time
// through the store's single read and single write port, one byte per cycle.
// A field touches 1 to 5 bytes. A zero-length field touches no byte, so its
// read goes straight to extraction and the clamps and its write straight to
// the result, as does the unused command. Writes read each touched byte and
// write the merged byte back in the next cycle, overlapped with the read of
// the next byte. The output sits in its own register, so the next command is
// accepted while an earlier result still waits to be transferred. The store
// is not cleared after reset; a field that was never written reads as
// undefined.
module packed_bitfield_store
    import pbs_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire         [CMD_W-1:0]    command,
    input  wire         [OFFSET_W-1:0] bit_offset,
    input  wire         [LEN_W-1:0]    field_length,
    input  wire         [VALUE_W-1:0]  write_value,
    input  wire  signed [BOUND_W-1:0]  lower_bound,
    input  wire  signed [BOUND_W-1:0]  upper_bound,
    input  wire         [LEN_W-1:0]    type_bits,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic signed [BOUND_W-1:0]  read_value,
    output logic                       length_error
);

    // Command and status between the sequencer and the datapath.
    pbs_ctrl_t   ctrl;
    pbs_status_t status;

    // The sequencer walks each command through the steps it needs: address
    // reduction, the byte transfers, extraction and the two clamp steps for reads, and the result hand-off.
    pbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (ctrl)
    );

    // The datapath holds the store, the byte window and the result register.
    pbs_datapath #(
        .STORE_BYTES (STORE_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctrl),
        .status       (status),
        .command      (command),
        .bit_offset   (bit_offset),
        .field_length (field_length),
        .write_value  (write_value),
        .lower_bound  (lower_bound),
        .upper_bound  (upper_bound),
        .type_bits    (type_bits),
        .read_value   (read_value),
        .length_error (length_error)
    );

endmodule

`default_nettype wire
